FILE: rtl/whtp_pkg.sv
// ----------------------------------------------------------------------------
// whtp_pkg
// Shared types, codes and defaults of the windowed tile handle pool.
// ----------------------------------------------------------------------------
package whtp_pkg;

  localparam int COORD_W      = 28;
  localparam int HANDLE_W_MAX = 16;
  localparam int LI_W_MAX     = 5;
  localparam int COUNT_W      = 7;
  localparam int FCOUNT_W     = 9;

  localparam logic [COUNT_W-1:0] PREALLOC_MAX = 7'd64;

  localparam int DEF_FIRST_LAYER = 0;
  localparam int DEF_LAYER_COUNT = 8;
  localparam int DEF_WINDOW_DIM  = 16;
  localparam int DEF_FREE_DEPTH  = 256;
  localparam int DEF_HANDLE_BITS = 8;

  localparam logic [1:0] CMD_GET      = 2'd0;
  localparam logic [1:0] CMD_PUT      = 2'd1;
  localparam logic [1:0] CMD_REWINDOW = 2'd2;
  localparam logic [1:0] CMD_PREALLOC = 2'd3;

  typedef enum logic [2:0] {
    ST_SLOT        = 3'd0,
    ST_FREE        = 3'd1,
    ST_FRESH       = 3'd2,
    ST_BAD_LAYER   = 3'd3,
    ST_OUTSIDE     = 3'd4,
    ST_BAD_WINDOW  = 3'd5,
    ST_STACK_FULL  = 3'd6,
    ST_EXHAUSTED   = 3'd7
  } status_t;

  typedef enum logic [2:0] {
    K_GET,
    K_PUT,
    K_REWIN,
    K_PRE,
    K_BAD_LAYER,
    K_BAD_WINDOW
  } kind_t;

  typedef struct packed {
    kind_t                   kind;
    logic [LI_W_MAX-1:0]     li;
    logic [COORD_W-1:0]      x;
    logic [COORD_W-1:0]      y;
    logic [HANDLE_W_MAX-1:0] handle;
    logic [COORD_W-1:0]      nxl;
    logic [COORD_W-1:0]      nxh;
    logic [COORD_W-1:0]      nyl;
    logic [COORD_W-1:0]      nyh;
    logic [COUNT_W-1:0]      count;
  } cmd_t;

  typedef struct packed {
    logic [HANDLE_W_MAX-1:0] handle;
    status_t                 status;
    logic [FCOUNT_W-1:0]     free_count;
    logic                    last;
  } res_t;

  typedef enum logic [3:0] {
    B_CLEAR,
    B_IDLE,
    B_CHK,
    B_GET_DEC,
    B_POP_DATA,
    B_EMIT,
    B_PRE,
    B_RW_CLR,
    B_RW_RD,
    B_RW_PROC
  } back_state_t;

endpackage

FILE: rtl/whtp_front.sv
// ----------------------------------------------------------------------------
// whtp_front
// Accepts requests, classifies them and queues the decoded commands.
// ----------------------------------------------------------------------------
module whtp_front #(
  parameter int FIRST_LAYER = whtp_pkg::DEF_FIRST_LAYER,
  parameter int LAYER_COUNT = whtp_pkg::DEF_LAYER_COUNT,
  parameter int WINDOW_DIM  = whtp_pkg::DEF_WINDOW_DIM,
  parameter int HANDLE_BITS = whtp_pkg::DEF_HANDLE_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic [1:0]                   command,
  input  logic [7:0]                   layer,
  input  logic [whtp_pkg::COORD_W-1:0] x_coord,
  input  logic [whtp_pkg::COORD_W-1:0] y_coord,
  input  logic [7:0]                   tile_handle,
  input  logic [whtp_pkg::COORD_W-1:0] new_x_low,
  input  logic [whtp_pkg::COORD_W-1:0] new_x_high,
  input  logic [whtp_pkg::COORD_W-1:0] new_y_low,
  input  logic [whtp_pkg::COORD_W-1:0] new_y_high,
  input  logic [whtp_pkg::COUNT_W-1:0] prealloc_count,
  output logic                         cmd_valid,
  input  logic                         cmd_pop,
  output whtp_pkg::cmd_t               cmd
);

  function automatic logic span_ok(input logic [whtp_pkg::COORD_W-1:0] lo,
                                   input logic [whtp_pkg::COORD_W-1:0] hi);
    span_ok = (hi < lo) || ((hi - lo) < whtp_pkg::COORD_W'(WINDOW_DIM));
  endfunction

  whtp_pkg::cmd_t q [2];
  logic           wptr;
  logic           rptr;
  logic [1:0]     cnt;
  whtp_pkg::cmd_t ent;
  logic [8:0]     lay_off;
  logic           lay_ok;
  logic [16:0]    hmask;
  logic           do_push;
  logic           do_pop;

  always_comb begin
    lay_off = {1'b0, layer} - 9'(FIRST_LAYER);
    lay_ok  = ({1'b0, layer} >= 9'(FIRST_LAYER)) && (lay_off < 9'(LAYER_COUNT));
    hmask   = (17'd1 << HANDLE_BITS) - 17'd1;
    ent.li     = whtp_pkg::LI_W_MAX'(lay_off);
    ent.x      = x_coord;
    ent.y      = y_coord;
    ent.handle = {8'b0, tile_handle} & hmask[15:0];
    ent.nxl    = new_x_low;
    ent.nxh    = new_x_high;
    ent.nyl    = new_y_low;
    ent.nyh    = new_y_high;
    ent.count  = (prealloc_count > whtp_pkg::PREALLOC_MAX) ? whtp_pkg::PREALLOC_MAX
                                                            : prealloc_count;
    if (command == whtp_pkg::CMD_PREALLOC) begin
      ent.kind = whtp_pkg::K_PRE;
    end else if (!lay_ok) begin
      ent.kind = whtp_pkg::K_BAD_LAYER;
    end else if (command == whtp_pkg::CMD_GET) begin
      ent.kind = whtp_pkg::K_GET;
    end else if (command == whtp_pkg::CMD_PUT) begin
      ent.kind = whtp_pkg::K_PUT;
    end else if (span_ok(new_x_low, new_x_high) && span_ok(new_y_low, new_y_high)) begin
      ent.kind = whtp_pkg::K_REWIN;
    end else begin
      ent.kind = whtp_pkg::K_BAD_WINDOW;
    end
  end

  assign full      = (cnt == 2'd2);
  assign cmd_valid = (cnt != 2'd0);
  assign cmd       = q[rptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wptr] <= ent;
    end
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (do_push) wptr <= ~wptr;
      if (do_pop)  rptr <= ~rptr;
      cnt <= cnt + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

FILE: rtl/whtp_back.sv
// ----------------------------------------------------------------------------
// whtp_back
// Carries out queued commands on the slot memory and the free stack.
// ----------------------------------------------------------------------------
module whtp_back #(
  parameter int LAYER_COUNT = whtp_pkg::DEF_LAYER_COUNT,
  parameter int WINDOW_DIM  = whtp_pkg::DEF_WINDOW_DIM,
  parameter int FREE_DEPTH  = whtp_pkg::DEF_FREE_DEPTH,
  parameter int HANDLE_BITS = whtp_pkg::DEF_HANDLE_BITS
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  whtp_pkg::cmd_t cmd,
  output logic           cmd_pop,
  input  logic           res_full,
  output logic           res_push,
  output whtp_pkg::res_t res
);

  localparam int SLOTS = WINDOW_DIM * WINDOW_DIM;
  localparam int POSW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int DW    = (WINDOW_DIM > 1) ? $clog2(WINDOW_DIM) : 1;
  localparam int TOTAL = LAYER_COUNT * 2 * SLOTS;
  localparam int AW    = $clog2(TOTAL);
  localparam int LIW   = (LAYER_COUNT > 1) ? $clog2(LAYER_COUNT) : 1;
  localparam int SAW   = $clog2(FREE_DEPTH);
  localparam int FTW   = $clog2(FREE_DEPTH + 1);
  localparam int HB    = HANDLE_BITS;
  localparam int CW    = whtp_pkg::COORD_W;

  function automatic logic [AW-1:0] slot_addr(input logic [LIW-1:0] li,
                                              input logic b,
                                              input logic [POSW-1:0] pos);
    logic [31:0] t;
    t = ((32'(li) * 2 + 32'(b)) * SLOTS) + 32'(pos);
    slot_addr = t[AW-1:0];
  endfunction

  function automatic logic [POSW-1:0] grid_pos(input logic [DW-1:0] a,
                                               input logic [DW-1:0] b);
    logic [31:0] t;
    t = 32'(a) * WINDOW_DIM + 32'(b);
    grid_pos = t[POSW-1:0];
  endfunction

  // memories
  logic [HB-1:0] slot_mem [TOTAL];
  logic [HB-1:0] stack_mem [FREE_DEPTH];
  logic          slot_we;
  logic [AW-1:0] slot_waddr;
  logic [AW-1:0] slot_raddr;
  logic [HB-1:0] slot_wdata;
  logic [HB-1:0] slot_rdata;
  logic          stack_we;
  logic [SAW-1:0] stack_waddr;
  logic [SAW-1:0] stack_raddr;
  logic [HB-1:0] stack_wdata;
  logic [HB-1:0] stack_rdata;

  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
    slot_rdata <= slot_mem[slot_raddr];
  end

  always_ff @(posedge clk) begin
    if (stack_we) stack_mem[stack_waddr] <= stack_wdata;
    stack_rdata <= stack_mem[stack_raddr];
  end

  // state
  whtp_pkg::back_state_t state, state_next;
  logic [CW-1:0]  wxl [LAYER_COUNT];
  logic [CW-1:0]  wxh [LAYER_COUNT];
  logic [CW-1:0]  wyl [LAYER_COUNT];
  logic [CW-1:0]  wyh [LAYER_COUNT];
  logic           bank [LAYER_COUNT];
  logic           win_we;
  logic [FTW-1:0] free_top, free_top_next;
  logic [HB:0]    nfh, nfh_next;
  logic [AW-1:0]  clr_cnt, clr_cnt_next;
  whtp_pkg::cmd_t cur, cur_next;
  logic           chk_in, chk_in_next;
  logic [AW-1:0]  chk_addr, chk_addr_next;
  logic [POSW-1:0] rw_k, rw_k_next;
  logic [DW-1:0]  dx, dx_next, dy, dy_next;
  logic           rw_err, rw_err_next;
  logic [whtp_pkg::COUNT_W-1:0] pre_left, pre_left_next;
  logic [HB-1:0]  res_h, res_h_next;
  whtp_pkg::status_t res_st, res_st_next;

  // working values
  logic [LIW-1:0] li;
  logic [CW-1:0]  cxl, cxh, cyl, cyh;
  logic           cbank;
  logic [CW-1:0]  ddx, ddy;
  logic           in_win;
  logic [AW-1:0]  chk_a;
  logic [CW:0]    ox, oy, ndx, ndy;
  logic           old_in, new_in;
  logic [HB-1:0]  get_h;
  logic [FTW-1:0] ft_dec;
  logic           stack_full;
  logic           rw_done;

  always_comb begin
    li    = cur.li[LIW-1:0];
    cxl   = wxl[li];
    cxh   = wxh[li];
    cyl   = wyl[li];
    cyh   = wyh[li];
    cbank = bank[li];
    ddx   = cur.x - cxl;
    ddy   = cur.y - cyl;
    in_win = (cur.x >= cxl) && (cur.x <= cxh) && (cur.y >= cyl) && (cur.y <= cyh) &&
             (ddx < CW'(WINDOW_DIM)) && (ddy < CW'(WINDOW_DIM));
    chk_a  = slot_addr(li, cbank, grid_pos(ddx[DW-1:0], ddy[DW-1:0]));
    ox     = {1'b0, cxl} + (CW+1)'(dx);
    oy     = {1'b0, cyl} + (CW+1)'(dy);
    ndx    = ox - {1'b0, cur.nxl};
    ndy    = oy - {1'b0, cur.nyl};
    old_in = (ox <= {1'b0, cxh}) && (oy <= {1'b0, cyh});
    new_in = (ox >= {1'b0, cur.nxl}) && (ox <= {1'b0, cur.nxh}) &&
             (oy >= {1'b0, cur.nyl}) && (oy <= {1'b0, cur.nyh}) &&
             (ndx < (CW+1)'(WINDOW_DIM)) && (ndy < (CW+1)'(WINDOW_DIM));
    get_h      = chk_in ? slot_rdata : '0;
    ft_dec     = free_top - FTW'(1);
    stack_full = (free_top == FTW'(FREE_DEPTH));
    rw_done    = (dx == DW'(WINDOW_DIM - 1)) && (dy == DW'(WINDOW_DIM - 1));
  end

  always_comb begin
    state_next    = state;
    free_top_next = free_top;
    nfh_next      = nfh;
    clr_cnt_next  = clr_cnt;
    cur_next      = cur;
    chk_in_next   = chk_in;
    chk_addr_next = chk_addr;
    rw_k_next     = rw_k;
    dx_next       = dx;
    dy_next       = dy;
    rw_err_next   = rw_err;
    pre_left_next = pre_left;
    res_h_next    = res_h;
    res_st_next   = res_st;
    win_we        = 1'b0;
    cmd_pop       = 1'b0;
    res_push      = 1'b0;
    res           = '0;
    slot_we       = 1'b0;
    slot_waddr    = chk_addr;
    slot_wdata    = '0;
    slot_raddr    = chk_a;
    stack_we      = 1'b0;
    stack_waddr   = free_top[SAW-1:0];
    stack_wdata   = nfh[HB-1:0];
    stack_raddr   = ft_dec[SAW-1:0];

    case (state)
      whtp_pkg::B_CLEAR: begin
        slot_we      = 1'b1;
        slot_waddr   = clr_cnt;
        clr_cnt_next = clr_cnt + AW'(1);
        if (clr_cnt == AW'(TOTAL - 1)) state_next = whtp_pkg::B_IDLE;
      end

      whtp_pkg::B_IDLE: begin
        if (cmd_valid) begin
          cmd_pop  = 1'b1;
          cur_next = cmd;
          res_h_next = '0;
          case (cmd.kind)
            whtp_pkg::K_GET, whtp_pkg::K_PUT: state_next = whtp_pkg::B_CHK;
            whtp_pkg::K_REWIN: begin
              rw_k_next   = '0;
              rw_err_next = 1'b0;
              state_next  = whtp_pkg::B_RW_CLR;
            end
            whtp_pkg::K_PRE: begin
              pre_left_next = cmd.count;
              if (cmd.count != '0) state_next = whtp_pkg::B_PRE;
            end
            whtp_pkg::K_BAD_LAYER: begin
              res_st_next = whtp_pkg::ST_BAD_LAYER;
              state_next  = whtp_pkg::B_EMIT;
            end
            whtp_pkg::K_BAD_WINDOW: begin
              res_st_next = whtp_pkg::ST_BAD_WINDOW;
              state_next  = whtp_pkg::B_EMIT;
            end
            default: state_next = whtp_pkg::B_IDLE;
          endcase
        end
      end

      whtp_pkg::B_CHK: begin
        chk_in_next   = in_win;
        chk_addr_next = chk_a;
        if (cur.kind == whtp_pkg::K_PUT) begin
          slot_we     = in_win;
          slot_waddr  = chk_a;
          slot_wdata  = cur.handle[HB-1:0];
          res_st_next = in_win ? whtp_pkg::ST_SLOT : whtp_pkg::ST_OUTSIDE;
          state_next  = whtp_pkg::B_EMIT;
        end else begin
          state_next = whtp_pkg::B_GET_DEC;
        end
      end

      whtp_pkg::B_GET_DEC: begin
        // take the slot's handle and clear it; if it is empty, use the free stack or a fresh handle
        slot_we = chk_in;
        if (get_h != '0) begin
          res_h_next  = get_h;
          res_st_next = whtp_pkg::ST_SLOT;
          state_next  = whtp_pkg::B_EMIT;
        end else if (free_top != '0) begin
          free_top_next = ft_dec;
          state_next    = whtp_pkg::B_POP_DATA;
        end else if (!nfh[HB]) begin
          res_h_next  = nfh[HB-1:0];
          res_st_next = whtp_pkg::ST_FRESH;
          nfh_next    = nfh + (HB+1)'(1);
          state_next  = whtp_pkg::B_EMIT;
        end else begin
          res_st_next = whtp_pkg::ST_EXHAUSTED;
          state_next  = whtp_pkg::B_EMIT;
        end
      end

      whtp_pkg::B_POP_DATA: begin
        res_h_next  = stack_rdata;
        res_st_next = whtp_pkg::ST_FREE;
        state_next  = whtp_pkg::B_EMIT;
      end

      whtp_pkg::B_EMIT: begin
        res.handle     = whtp_pkg::HANDLE_W_MAX'(res_h);
        res.status     = res_st;
        res.free_count = whtp_pkg::FCOUNT_W'(free_top);
        res.last       = 1'b1;
        if (!res_full) begin
          res_push   = 1'b1;
          state_next = whtp_pkg::B_IDLE;
        end
      end

      whtp_pkg::B_PRE: begin
        res.last = (pre_left == whtp_pkg::COUNT_W'(1));
        if (stack_full) begin
          res.status     = whtp_pkg::ST_STACK_FULL;
          res.free_count = whtp_pkg::FCOUNT_W'(free_top);
        end else if (nfh[HB]) begin
          res.status     = whtp_pkg::ST_EXHAUSTED;
          res.free_count = whtp_pkg::FCOUNT_W'(free_top);
        end else begin
          res.handle     = whtp_pkg::HANDLE_W_MAX'(nfh[HB-1:0]);
          res.status     = whtp_pkg::ST_FRESH;
          res.free_count = whtp_pkg::FCOUNT_W'(free_top + FTW'(1));
        end
        if (!res_full) begin
          res_push      = 1'b1;
          pre_left_next = pre_left - whtp_pkg::COUNT_W'(1);
          if (!stack_full && !nfh[HB]) begin
            stack_we      = 1'b1;
            free_top_next = free_top + FTW'(1);
            nfh_next      = nfh + (HB+1)'(1);
          end
          if (res.last) state_next = whtp_pkg::B_IDLE;
        end
      end

      whtp_pkg::B_RW_CLR: begin
        // clear the spare bank before relocating into it
        slot_we    = 1'b1;
        slot_waddr = slot_addr(li, ~cbank, rw_k);
        rw_k_next  = rw_k + POSW'(1);
        if (rw_k == POSW'(SLOTS - 1)) begin
          dx_next    = '0;
          dy_next    = '0;
          state_next = whtp_pkg::B_RW_RD;
        end
      end

      whtp_pkg::B_RW_RD: begin
        slot_raddr = slot_addr(li, cbank, grid_pos(dx, dy));
        state_next = whtp_pkg::B_RW_PROC;
      end

      whtp_pkg::B_RW_PROC: begin
        if (old_in && slot_rdata != '0) begin
          if (new_in) begin
            slot_we    = 1'b1;
            slot_waddr = slot_addr(li, ~cbank, grid_pos(ndx[DW-1:0], ndy[DW-1:0]));
            slot_wdata = slot_rdata;
          end else if (!stack_full) begin
            stack_we      = 1'b1;
            stack_wdata   = slot_rdata;
            free_top_next = free_top + FTW'(1);
          end else begin
            rw_err_next = 1'b1;
          end
        end
        if (dy == DW'(WINDOW_DIM - 1)) begin
          dy_next = '0;
          dx_next = dx + DW'(1);
        end else begin
          dy_next = dy + DW'(1);
        end
        if (rw_done) begin
          win_we      = 1'b1;
          res_st_next = rw_err_next ? whtp_pkg::ST_STACK_FULL : whtp_pkg::ST_SLOT;
          state_next  = whtp_pkg::B_EMIT;
        end else begin
          state_next = whtp_pkg::B_RW_RD;
        end
      end

      default: state_next = whtp_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= whtp_pkg::B_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    cur      <= cur_next;
    chk_in   <= chk_in_next;
    chk_addr <= chk_addr_next;
    rw_k     <= rw_k_next;
    dx       <= dx_next;
    dy       <= dy_next;
    rw_err   <= rw_err_next;
    pre_left <= pre_left_next;
    res_h    <= res_h_next;
    res_st   <= res_st_next;
    if (rst) begin
      free_top <= '0;
      nfh      <= (HB+1)'(1);
      clr_cnt  <= '0;
      for (int i = 0; i < LAYER_COUNT; i++) begin
        wxl[i]  <= '0;
        wxh[i]  <= '0;
        wyl[i]  <= '0;
        wyh[i]  <= '0;
        bank[i] <= 1'b0;
      end
    end else begin
      free_top <= free_top_next;
      nfh      <= nfh_next;
      clr_cnt  <= clr_cnt_next;
      if (win_we) begin
        wxl[li]  <= cur.nxl;
        wxh[li]  <= cur.nxh;
        wyl[li]  <= cur.nyl;
        wyh[li]  <= cur.nyh;
        bank[li] <= ~cbank;
      end
    end
  end

endmodule

FILE: rtl/whtp_outq.sv
// ----------------------------------------------------------------------------
// whtp_outq
// Two-entry result queue between the execution engine and the receiver.
// ----------------------------------------------------------------------------
module whtp_outq (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  whtp_pkg::res_t din,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output whtp_pkg::res_t dout
);

  whtp_pkg::res_t q [2];
  logic           wptr;
  logic           rptr;
  logic [1:0]     cnt;
  logic           do_push;
  logic           do_pop;

  assign full    = (cnt == 2'd2);
  assign empty   = (cnt == 2'd0);
  assign dout    = q[rptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wptr] <= din;
    end
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (do_push) wptr <= ~wptr;
      if (do_pop)  rptr <= ~rptr;
      cnt <= cnt + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

FILE: rtl/windowed_tile_handle_pool_unit.sv
// ----------------------------------------------------------------------------
// windowed_tile_handle_pool_unit
// Pool of tile handles with per-layer coordinate windows and a free stack.
// ----------------------------------------------------------------------------
// Requests enter through push/full; a request is taken when push is high and
// full is low. Results leave through empty/pop; the oldest result sits on the
// result ports while empty is low and is taken when pop is high.
// A two-entry command queue sits between the decode front and the execution
// engine, and a two-entry result queue sits behind the engine, so requests
// keep being taken while a result waits.
// The slot memory read is registered. A put checks the window and emits;
// a get checks the window, reads and clears the slot, falls back to the
// free stack or a fresh handle if it was empty, and emits; a bad layer or
// bad window emits at once; a preallocate emits one result per handle
// asked for, pushing fresh handles while the stack has room; a rewindow
// clears the spare bank, reads and processes each old slot, and emits.
// After reset the engine clears the 2*LAYER_COUNT*WINDOW_DIM^2 slot memory
// entries (4096 by default), one per cycle; up to two requests are
// queued meanwhile. When the receiver stalls the result queue fills, the
// engine holds, and full rises once the command queue is also full.
// ----------------------------------------------------------------------------
module windowed_tile_handle_pool_unit #(
  parameter int FIRST_LAYER = whtp_pkg::DEF_FIRST_LAYER,
  parameter int LAYER_COUNT = whtp_pkg::DEF_LAYER_COUNT,
  parameter int WINDOW_DIM  = whtp_pkg::DEF_WINDOW_DIM,
  parameter int FREE_DEPTH  = whtp_pkg::DEF_FREE_DEPTH,
  parameter int HANDLE_BITS = whtp_pkg::DEF_HANDLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [1:0]                    command,
  input  logic [7:0]                    layer,
  input  logic [whtp_pkg::COORD_W-1:0]  x_coord,
  input  logic [whtp_pkg::COORD_W-1:0]  y_coord,
  input  logic [7:0]                    tile_handle,
  input  logic [whtp_pkg::COORD_W-1:0]  new_x_low,
  input  logic [whtp_pkg::COORD_W-1:0]  new_x_high,
  input  logic [whtp_pkg::COORD_W-1:0]  new_y_low,
  input  logic [whtp_pkg::COORD_W-1:0]  new_y_high,
  input  logic [whtp_pkg::COUNT_W-1:0]  prealloc_count,
  output logic                          empty,
  input  logic                          pop,
  output logic [7:0]                    out_handle,
  output logic [2:0]                    status,
  output logic [whtp_pkg::FCOUNT_W-1:0] free_count,
  output logic                          last
);

  whtp_pkg::cmd_t cmd;
  logic           cmd_valid;
  logic           cmd_pop;
  whtp_pkg::res_t res;
  whtp_pkg::res_t res_out;
  logic           res_push;
  logic           res_full;

  whtp_front #(
    .FIRST_LAYER (FIRST_LAYER),
    .LAYER_COUNT (LAYER_COUNT),
    .WINDOW_DIM  (WINDOW_DIM),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .command        (command),
    .layer          (layer),
    .x_coord        (x_coord),
    .y_coord        (y_coord),
    .tile_handle    (tile_handle),
    .new_x_low      (new_x_low),
    .new_x_high     (new_x_high),
    .new_y_low      (new_y_low),
    .new_y_high     (new_y_high),
    .prealloc_count (prealloc_count),
    .cmd_valid      (cmd_valid),
    .cmd_pop        (cmd_pop),
    .cmd            (cmd)
  );

  whtp_back #(
    .LAYER_COUNT (LAYER_COUNT),
    .WINDOW_DIM  (WINDOW_DIM),
    .FREE_DEPTH  (FREE_DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  whtp_outq u_outq (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res),
    .full  (res_full),
    .pop   (pop),
    .empty (empty),
    .dout  (res_out)
  );

  assign out_handle = res_out.handle[7:0];
  assign status     = res_out.status;
  assign free_count = res_out.free_count;
  assign last       = res_out.last;

  a_no_res_overflow: assert property (@(posedge clk) disable iff (rst)
    !(res_push && res_full))
    else $error("result pushed into a full result queue");

  a_no_cmd_underflow: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> cmd_valid)
    else $error("command taken from an empty queue");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty)
    else $error("result queue not empty after reset");

endmodule
